// ----- sv/distance_vector_route_update_defines.svh -----
// Assertion macros for the distance-vector route update block.
// Used by the top level; relies on clk and arst_n in the including scope.
`ifndef DISTANCE_VECTOR_ROUTE_UPDATE_DEFINES_SVH
`define DISTANCE_VECTOR_ROUTE_UPDATE_DEFINES_SVH
`ifndef ASSERT_OFF
`define DVRU_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("dvru assertion failed");
`define DVRU_ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dvru assertion failed");
`define DVRU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dvru assertion failed");
`else
`define DVRU_ASSERT(lbl, prop)
`define DVRU_ASSERT_IMPLIES(lbl, ante, cons)
`define DVRU_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- sv/dvru_pkg.sv -----
// Shared types and constants of the distance-vector route update block.
// No dependencies; used by dvru_cell and distance_vector_route_update.
`default_nettype none
package dvru_pkg;

	localparam int NAME_W            = 8;
	localparam int DIST_W            = 16;
	localparam int DEF_TABLE_ENTRIES = 16;
	localparam int MAX_RESULTS       = 16;
	localparam int ADV_CNT_W         = $clog2(MAX_RESULTS + 1);

	localparam logic [NAME_W-1:0] OWN_HOP  = 8'h2D;
	localparam logic [DIST_W-1:0] DIST_MAX = 16'hFFFF;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_ADD_NB = 2'd1,
		OP_VECTOR = 2'd2,
		OP_ADVERT = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		KIND_DONE     = 3'd0,
		KIND_IMPROVED = 3'd1,
		KIND_INSERTED = 3'd2,
		KIND_NOCHANGE = 3'd3,
		KIND_SKIPPED  = 3'd4,
		KIND_UNKNOWN  = 3'd5,
		KIND_FULL     = 3'd6,
		KIND_ADVERT   = 3'd7
	} kind_t;

	typedef struct packed {
		logic [NAME_W-1:0] dest;
		logic [NAME_W-1:0] hop;
		logic [DIST_W-1:0] metric;
		logic              nb;
	} route_entry_t;

	typedef struct packed {
		logic shift;
		logic clear;
		logic write;
	} cell_ctrl_t;

endpackage
`default_nettype wire

// ----- sv/dvru_cell.sv -----
// One routing table slot of the rotating route ring.
// Depends on dvru_pkg for the entry and control types.
`default_nettype none
module dvru_cell (
	input  wire                   clk,
	input  wire                   arst_n,
	input  dvru_pkg::cell_ctrl_t   ctrl,
	input  dvru_pkg::route_entry_t nxt,
	input  dvru_pkg::route_entry_t wr_data,
	output dvru_pkg::route_entry_t ent
);

	dvru_pkg::route_entry_t ent_q;

	// write beats clear so the own route lands in the same cycle as a clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else if (ctrl.write) begin
			ent_q <= wr_data;
		end else if (ctrl.clear) begin
			ent_q <= '0;
		end else if (ctrl.shift) begin
			ent_q <= nxt;
		end
	end

	assign ent = ent_q;

endmodule
`default_nettype wire

// ----- sv/distance_vector_route_update.sv -----
// Distance-vector route update engine: a ring of TABLE_ENTRIES route cells.
// Flow: a clear goes from IDLE straight to FINISH; other ops rotate the ring once in SCAN,
// then FINISH registers the result. in_stall stays high until the engine is back in IDLE, so a new
// item is taken only after the last one's result; out_stall holds FINISH and, for advertise, SCAN.
// Reset: arst_n asynchronously empties the table, zeroes self_name, drops pending output.
`default_nettype none
`include "distance_vector_route_update_defines.svh"
module distance_vector_route_update #(
	parameter int TABLE_ENTRIES = dvru_pkg::DEF_TABLE_ENTRIES
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire [dvru_pkg::NAME_W-1:0]   cfg_data,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire [1:0]                    op,
	input  wire [dvru_pkg::NAME_W-1:0]   sender_name,
	input  wire [dvru_pkg::NAME_W-1:0]   dest_name,
	input  wire [dvru_pkg::DIST_W-1:0]   distance,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic [2:0]                   kind,
	output logic [dvru_pkg::NAME_W-1:0]  entry_name,
	output logic [dvru_pkg::DIST_W-1:0]  entry_distance,
	output logic                         last
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
	localparam int ACW = dvru_pkg::ADV_CNT_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t                        state_q;
	logic [dvru_pkg::NAME_W-1:0]   self_q;
	dvru_pkg::op_t                 op_q;
	logic [dvru_pkg::NAME_W-1:0]   sender_q;
	logic [dvru_pkg::NAME_W-1:0]   dest_q;
	logic [dvru_pkg::DIST_W-1:0]   dist_q;
	logic [IDX_W-1:0]              cnt_q;

	logic                          snd_found_q;
	logic [dvru_pkg::DIST_W-1:0]   snd_dist_q;
	logic                          dst_found_q;
	logic [IDX_W-1:0]              dst_idx_q;
	logic [dvru_pkg::DIST_W-1:0]   dst_dist_q;
	logic                          dst_nb_q;
	logic                          emp_found_q;
	logic [IDX_W-1:0]              emp_idx_q;

	logic                          pv_q;
	logic [dvru_pkg::NAME_W-1:0]   pend_name_q;
	logic [dvru_pkg::DIST_W-1:0]   pend_dist_q;
	logic [ACW-1:0]                adv_n_q;

	logic                          out_valid_q;
	dvru_pkg::kind_t               out_kind_q;
	logic [dvru_pkg::NAME_W-1:0]   out_name_q;
	logic [dvru_pkg::DIST_W-1:0]   out_dist_q;
	logic                          out_last_q;

	dvru_pkg::route_entry_t        ents [TABLE_ENTRIES];
	dvru_pkg::route_entry_t        head;
	dvru_pkg::route_entry_t        fin_entry;

	logic                          in_acc;
	logic                          out_free;
	logic                          occ;
	logic                          adv_take;
	logic                          scan_shift;
	logic                          adv_emit;
	logic                          fin_go;
	logic                          fin_wr;
	logic [IDX_W-1:0]              fin_idx;
	dvru_pkg::kind_t               fin_kind;
	logic [dvru_pkg::NAME_W-1:0]   fin_name;
	logic [dvru_pkg::DIST_W-1:0]   fin_dist;
	logic [dvru_pkg::DIST_W:0]     cost_sum;
	logic [dvru_pkg::DIST_W-1:0]   cost;
	logic                          skip;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	assign head = ents[0];
	assign occ  = (head.dest != '0);

	// advertise holds the ring while a captured entry cannot leave
	assign adv_take   = (op_q == dvru_pkg::OP_ADVERT) && occ
		&& (adv_n_q < ACW'(dvru_pkg::MAX_RESULTS));
	assign scan_shift = (state_q == ST_SCAN) && !(adv_take && pv_q && !out_free);
	assign adv_emit   = (state_q == ST_SCAN) && adv_take && pv_q && out_free;
	assign fin_go     = (state_q == ST_FINISH) && out_free;

	assign cost_sum = {1'b0, dist_q} + {1'b0, snd_dist_q};
	assign cost     = cost_sum[dvru_pkg::DIST_W] ? dvru_pkg::DIST_MAX
		: cost_sum[dvru_pkg::DIST_W-1:0];
	assign skip     = (dest_q == '0) || (dest_q == self_q);

	always_comb begin
		fin_kind  = dvru_pkg::KIND_DONE;
		fin_name  = '0;
		fin_dist  = '0;
		fin_wr    = 1'b0;
		fin_idx   = '0;
		fin_entry = '0;
		unique case (op_q)
			dvru_pkg::OP_CLEAR: begin
				fin_wr         = 1'b1;
				fin_entry.dest = self_q;
				fin_entry.hop  = dvru_pkg::OWN_HOP;
			end
			dvru_pkg::OP_ADD_NB: begin
				fin_entry.dest   = dest_q;
				fin_entry.hop    = dest_q;
				fin_entry.metric = dist_q;
				fin_entry.nb     = 1'b1;
				fin_dist         = dist_q;
				if (skip) begin
					fin_kind = dvru_pkg::KIND_SKIPPED;
					fin_dist = '0;
				end else if (dst_found_q) begin
					fin_kind = dvru_pkg::KIND_IMPROVED;
					fin_wr   = 1'b1;
					fin_idx  = dst_idx_q;
				end else if (emp_found_q) begin
					fin_kind = dvru_pkg::KIND_INSERTED;
					fin_wr   = 1'b1;
					fin_idx  = emp_idx_q;
				end else begin
					fin_kind = dvru_pkg::KIND_FULL;
				end
			end
			dvru_pkg::OP_VECTOR: begin
				fin_entry.dest   = dest_q;
				fin_entry.hop    = sender_q;
				fin_entry.metric = cost;
				fin_dist         = cost;
				if (!snd_found_q) begin
					fin_kind = dvru_pkg::KIND_UNKNOWN;
					fin_dist = '0;
				end else if (skip) begin
					fin_kind = dvru_pkg::KIND_SKIPPED;
					fin_dist = '0;
				end else if (dst_found_q) begin
					fin_idx      = dst_idx_q;
					fin_entry.nb = dst_nb_q;
					if (cost < dst_dist_q) begin
						fin_kind = dvru_pkg::KIND_IMPROVED;
						fin_wr   = 1'b1;
					end else begin
						fin_kind = dvru_pkg::KIND_NOCHANGE;
						fin_dist = dst_dist_q;
					end
				end else if (emp_found_q) begin
					fin_kind = dvru_pkg::KIND_INSERTED;
					fin_wr   = 1'b1;
					fin_idx  = emp_idx_q;
				end else begin
					fin_kind = dvru_pkg::KIND_FULL;
				end
			end
			dvru_pkg::OP_ADVERT: begin
				if (pv_q) begin
					fin_kind = dvru_pkg::KIND_ADVERT;
					fin_name = pend_name_q;
					fin_dist = pend_dist_q;
				end
			end
			default: begin
				fin_kind = dvru_pkg::KIND_DONE;
			end
		endcase
	end

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		dvru_pkg::cell_ctrl_t ctrl;

		assign ctrl.shift = scan_shift;
		assign ctrl.clear = fin_go && (op_q == dvru_pkg::OP_CLEAR);
		assign ctrl.write = fin_go && fin_wr && (fin_idx == IDX_W'(i));

		dvru_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.nxt     (ents[(i + 1) % TABLE_ENTRIES]),
			.wr_data (fin_entry),
			.ent     (ents[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			self_q      <= '0;
			op_q        <= dvru_pkg::OP_CLEAR;
			sender_q    <= '0;
			dest_q      <= '0;
			dist_q      <= '0;
			cnt_q       <= '0;
			snd_found_q <= 1'b0;
			snd_dist_q  <= '0;
			dst_found_q <= 1'b0;
			dst_idx_q   <= '0;
			dst_dist_q  <= '0;
			dst_nb_q    <= 1'b0;
			emp_found_q <= 1'b0;
			emp_idx_q   <= '0;
			pv_q        <= 1'b0;
			pend_name_q <= '0;
			pend_dist_q <= '0;
			adv_n_q     <= '0;
			out_valid_q <= 1'b0;
			out_kind_q  <= dvru_pkg::KIND_DONE;
			out_name_q  <= '0;
			out_dist_q  <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				self_q <= cfg_data;
			end

			if (adv_emit || fin_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						op_q        <= dvru_pkg::op_t'(op);
						sender_q    <= sender_name;
						dest_q      <= dest_name;
						dist_q      <= distance;
						cnt_q       <= '0;
						snd_found_q <= 1'b0;
						dst_found_q <= 1'b0;
						emp_found_q <= 1'b0;
						pv_q        <= 1'b0;
						adv_n_q     <= '0;
						state_q     <= (dvru_pkg::op_t'(op) == dvru_pkg::OP_CLEAR)
							? ST_FINISH : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_shift) begin
						// record first matches while the slot passes the head cell
						if (!snd_found_q && occ && head.dest == sender_q && head.nb) begin
							snd_found_q <= 1'b1;
							snd_dist_q  <= head.metric;
						end
						if (!dst_found_q && occ && head.dest == dest_q) begin
							dst_found_q <= 1'b1;
							dst_idx_q   <= cnt_q;
							dst_dist_q  <= head.metric;
							dst_nb_q    <= head.nb;
						end
						if (!emp_found_q && !occ) begin
							emp_found_q <= 1'b1;
							emp_idx_q   <= cnt_q;
						end
						if (adv_take) begin
							pv_q        <= 1'b1;
							pend_name_q <= head.dest;
							pend_dist_q <= head.metric;
							adv_n_q     <= adv_n_q + ACW'(1);
						end
						cnt_q <= cnt_q + IDX_W'(1);
						if (cnt_q == LAST_IDX) begin
							state_q <= ST_FINISH;
						end
					end
					if (adv_emit) begin
						out_kind_q <= dvru_pkg::KIND_ADVERT;
						out_name_q <= pend_name_q;
						out_dist_q <= pend_dist_q;
						out_last_q <= 1'b0;
					end
				end
				ST_FINISH: begin
					if (fin_go) begin
						out_kind_q <= fin_kind;
						out_name_q <= fin_name;
						out_dist_q <= fin_dist;
						out_last_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = out_kind_q;
	assign entry_name     = out_name_q;
	assign entry_distance = out_dist_q;
	assign last           = out_last_q;

	`DVRU_ASSERT(a_adv_cap, adv_n_q <= ACW'(dvru_pkg::MAX_RESULTS))
	`DVRU_ASSERT_NEXT(a_acc_busy, in_valid && !in_stall, state_q != ST_IDLE)
	`DVRU_ASSERT_IMPLIES(a_mid_advert, out_valid_q && !out_last_q,
		out_kind_q == dvru_pkg::KIND_ADVERT)
	`DVRU_ASSERT_IMPLIES(a_write_emits, fin_go && fin_wr, out_free)

endmodule
`default_nettype wire
